### rtl/jddm_pkg.sv
// ============================================================================
// Differential drive mixer package
// Widths, reset values, register indexes and the side-band types that travel
// with each sample through the pipelined dividers.
// ============================================================================
`default_nettype none

package jddm_pkg;

  localparam int DUTY_BITS_DEF = 8;

  localparam int STICK_W    = 11;  // signed joystick axis
  localparam int DZ_W       = 9;   // dead zone threshold
  localparam int SPEED_W    = 8;   // max_speed and axis magnitude
  localparam int GAIN_W     = 9;   // Q1.8 gain
  localparam int GAIN_SHIFT = 8;   // Q1.8 fraction bits

  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 9;

  // Full deflection of a stick axis.
  localparam int AXIS_FULL  = 512;

  // Axis magnitude goes up to 1024, so it needs one bit more than 512.
  localparam int AXIS_MAG_W = STICK_W;
  // Rescale divisor is 512 - dead zone, which lies in 1..512.
  localparam int AXIS_DEN_W = 10;
  // Every division yields an 8-bit quotient plus an overflow flag.
  localparam int QUO_W      = SPEED_W;
  localparam int AXIS_NUM_W = QUO_W + AXIS_DEN_W;
  // Mixed wheel magnitude goes up to 510.
  localparam int WHEEL_MAG_W = SPEED_W + 1;
  localparam int WHEEL_NUM_W = QUO_W + WHEEL_MAG_W;
  localparam int GAIN_PROD_W = QUO_W + GAIN_W;

  localparam logic [DZ_W-1:0]    DZ_X_RESET   = DZ_W'(90);
  localparam logic [DZ_W-1:0]    DZ_Y_RESET   = DZ_W'(50);
  localparam logic [SPEED_W-1:0] SPEED_RESET  = SPEED_W'(255);
  localparam logic [GAIN_W-1:0]  GAIN_RESET   = GAIN_W'(256);

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_DEADZONE_X = 3'd0,
    REG_DEADZONE_Y = 3'd1,
    REG_MAX_SPEED  = 3'd2,
    REG_GAIN_LEFT  = 3'd3,
    REG_GAIN_RIGHT = 3'd4
  } reg_index_t;

  // Side band of an axis through its rescale divider.
  typedef struct packed {
    logic conn;
    logic live;   // magnitude reached the dead zone edge
    logic pos;    // axis value is positive
  } axis_tag_t;

  // Side band of a wheel through its normalization divider.
  typedef struct packed {
    logic                   conn;
    logic                   need;  // larger wheel exceeds the larger axis
    logic                   neg;   // wheel speed is negative
    logic [WHEEL_MAG_W-1:0] mag;   // unnormalized wheel magnitude
  } wheel_tag_t;

endpackage

`default_nettype wire

### rtl/jddm_if.sv
// ============================================================================
// Differential drive mixer channels
// Valid/ready channels for joystick samples and for motor drive results.
// ============================================================================
`default_nettype none

interface jddm_in_if;
  logic                                valid;
  logic                                ready;
  logic signed [jddm_pkg::STICK_W-1:0] stick_x;
  logic signed [jddm_pkg::STICK_W-1:0] stick_y_raw;
  logic                                pad_connected;

  modport source (output valid, stick_x, stick_y_raw, pad_connected, input ready);
  modport sink (input valid, stick_x, stick_y_raw, pad_connected, output ready);
endinterface

interface jddm_out_if #(
  parameter int DUTY_BITS = jddm_pkg::DUTY_BITS_DEF
);
  logic                 valid;
  logic                 ready;
  logic                 left_fwd;
  logic                 left_rev;
  logic [DUTY_BITS-1:0] left_duty;
  logic                 right_fwd;
  logic                 right_rev;
  logic [DUTY_BITS-1:0] right_duty;

  modport source (
    output valid, left_fwd, left_rev, left_duty, right_fwd, right_rev, right_duty,
    input  ready
  );
  modport sink (
    input  valid, left_fwd, left_rev, left_duty, right_fwd, right_rev, right_duty,
    output ready
  );
endinterface

`default_nettype wire

### rtl/jddm_div_pipe.sv
// ============================================================================
// Pipelined restoring divider
// Unsigned division with one quotient bit per register stage. The quotient
// is QW bits wide; ovf flags a quotient that would not fit. A side band and
// a valid bit travel along with each transaction.
// ============================================================================
`default_nettype none

module jddm_div_pipe #(
  parameter int QW = jddm_pkg::QUO_W,
  parameter int DW = jddm_pkg::AXIS_DEN_W,
  parameter int SW = $bits(jddm_pkg::axis_tag_t)
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             en,
  input  logic             in_valid,
  input  logic [QW+DW-1:0] num,
  input  logic [DW-1:0]    den,
  input  logic [SW-1:0]    side_in,
  output logic             out_valid,
  output logic [QW-1:0]    quo,
  output logic             ovf,
  output logic [SW-1:0]    side_out
);

  // Stage registers. Remainder and remaining dividend bits are not needed
  // after the last step, so those arrays are one entry shorter.
  logic          valid_r [QW];
  logic [QW-1:0] quo_r   [QW];
  logic          ovf_r   [QW];
  logic [SW-1:0] side_r  [QW];
  logic [DW-1:0] den_r   [QW];
  logic [DW-1:0] rem_r   [QW-1];
  logic [QW-1:0] low_r   [QW-1];

  // Inputs and results of each step.
  logic          valid_in [QW];
  logic [QW-1:0] quo_in   [QW];
  logic          ovf_in   [QW];
  logic [SW-1:0] side_s   [QW];
  logic [DW-1:0] den_in   [QW];
  logic [DW-1:0] rem_in   [QW];
  logic [QW-1:0] low_in   [QW];
  logic [DW:0]   trial    [QW];
  logic [DW:0]   diff     [QW];
  logic          fits     [QW];
  logic [DW-1:0] rem_nx   [QW];
  logic [QW-1:0] low_nx   [QW];
  logic [QW-1:0] quo_nx   [QW];

  always_comb begin
    valid_in[0] = in_valid;
    quo_in[0]   = '0;
    // The quotient overflows exactly when the upper dividend bits reach den.
    ovf_in[0]   = num[QW +: DW] >= den;
    side_s[0]   = side_in;
    den_in[0]   = den;
    rem_in[0]   = num[QW +: DW];
    low_in[0]   = num[QW-1:0];
    for (int k = 1; k < QW; k++) begin
      valid_in[k] = valid_r[k-1];
      quo_in[k]   = quo_r[k-1];
      ovf_in[k]   = ovf_r[k-1];
      side_s[k]   = side_r[k-1];
      den_in[k]   = den_r[k-1];
      rem_in[k]   = rem_r[k-1];
      low_in[k]   = low_r[k-1];
    end
    for (int k = 0; k < QW; k++) begin
      trial[k]  = {rem_in[k], low_in[k][QW-1]};
      diff[k]   = trial[k] - {1'b0, den_in[k]};
      fits[k]   = trial[k] >= {1'b0, den_in[k]};
      rem_nx[k] = fits[k] ? diff[k][DW-1:0] : trial[k][DW-1:0];
      low_nx[k] = low_in[k] << 1;
      quo_nx[k] = {quo_in[k][QW-2:0], fits[k]};
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int k = 0; k < QW; k++) valid_r[k] <= 1'b0;
    end else if (en) begin
      for (int k = 0; k < QW; k++) valid_r[k] <= valid_in[k];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int k = 0; k < QW; k++) begin
        quo_r[k]  <= quo_nx[k];
        ovf_r[k]  <= ovf_in[k];
        side_r[k] <= side_s[k];
        den_r[k]  <= den_in[k];
      end
      for (int k = 0; k < QW - 1; k++) begin
        rem_r[k] <= rem_nx[k];
        low_r[k] <= low_nx[k];
      end
    end
  end

  assign out_valid = valid_r[QW-1];
  assign quo       = quo_r[QW-1];
  assign ovf       = ovf_r[QW-1];
  assign side_out  = side_r[QW-1];

endmodule

`default_nettype wire

### rtl/joystick_differential_drive_mixer.sv
// ============================================================================
// Joystick differential drive mixer
// Arcade-style mixing of one joystick sample into direction bits and PWM
// duty for the left and right motors of a two-wheel robot.
// ============================================================================
// The mixer accepts one sample per clock while the output is not stalled and
// returns the results in order. The pipeline is built from the two pipelined
// restoring dividers, axis rescaling and then wheel normalization, each of
// which resolves one quotient bit per register stage (8 stages each), plus
// seven stages of shaping, mixing, gain and output registers. The whole
// pipeline holds while a result waits on the output; nothing is dropped or
// repeated. Configuration registers are written through cfg_we/cfg_index/
// cfg_data and must only be changed while no sample is in flight.
`default_nettype none

module joystick_differential_drive_mixer #(
  parameter int DUTY_BITS = jddm_pkg::DUTY_BITS_DEF
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            cfg_we,
  input  logic [jddm_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [jddm_pkg::CFG_DATA_W-1:0] cfg_data,
  jddm_in_if.sink                         sample,
  jddm_out_if.source                      result
);

  localparam int STICK_W     = jddm_pkg::STICK_W;
  localparam int DZ_W        = jddm_pkg::DZ_W;
  localparam int SPEED_W     = jddm_pkg::SPEED_W;
  localparam int GAIN_W      = jddm_pkg::GAIN_W;
  localparam int GAIN_SHIFT  = jddm_pkg::GAIN_SHIFT;
  localparam int AXIS_MAG_W  = jddm_pkg::AXIS_MAG_W;
  localparam int AXIS_DEN_W  = jddm_pkg::AXIS_DEN_W;
  localparam int AXIS_NUM_W  = jddm_pkg::AXIS_NUM_W;
  localparam int QUO_W       = jddm_pkg::QUO_W;
  localparam int WHEEL_MAG_W = jddm_pkg::WHEEL_MAG_W;
  localparam int WHEEL_NUM_W = jddm_pkg::WHEEL_NUM_W;
  localparam int GAIN_PROD_W = jddm_pkg::GAIN_PROD_W;
  localparam int SCALED_W    = GAIN_PROD_W - GAIN_SHIFT;
  localparam int SAT_W       = (DUTY_BITS > SPEED_W) ? DUTY_BITS : SPEED_W;
  localparam logic [SAT_W-1:0] DUTY_MAX = SAT_W'((1 << DUTY_BITS) - 1);

  // --------------------------------------------------------------------------
  // Configuration registers
  // --------------------------------------------------------------------------
  logic [DZ_W-1:0]    deadzone_x;
  logic [DZ_W-1:0]    deadzone_y;
  logic [SPEED_W-1:0] max_speed;
  logic [GAIN_W-1:0]  gain_left;
  logic [GAIN_W-1:0]  gain_right;

  always_ff @(posedge clk) begin
    if (rst) begin
      deadzone_x <= jddm_pkg::DZ_X_RESET;
      deadzone_y <= jddm_pkg::DZ_Y_RESET;
      max_speed  <= jddm_pkg::SPEED_RESET;
      gain_left  <= jddm_pkg::GAIN_RESET;
      gain_right <= jddm_pkg::GAIN_RESET;
    end else if (cfg_we) begin
      unique case (jddm_pkg::reg_index_t'(cfg_index))
        jddm_pkg::REG_DEADZONE_X: deadzone_x <= cfg_data[DZ_W-1:0];
        jddm_pkg::REG_DEADZONE_Y: deadzone_y <= cfg_data[DZ_W-1:0];
        jddm_pkg::REG_MAX_SPEED:  max_speed  <= cfg_data[SPEED_W-1:0];
        jddm_pkg::REG_GAIN_LEFT:  gain_left  <= cfg_data[GAIN_W-1:0];
        jddm_pkg::REG_GAIN_RIGHT: gain_right <= cfg_data[GAIN_W-1:0];
        default: ;
      endcase
    end
  end

  // The pipeline moves as one; it holds only while a result is not taken.
  logic out_valid;
  logic adv;

  assign adv          = !out_valid || result.ready;
  assign sample.ready = adv;

  // --------------------------------------------------------------------------
  // Stage A: magnitudes and dead zone
  // --------------------------------------------------------------------------
  logic [AXIS_MAG_W-1:0] mag_x, mag_y;
  logic                  pos_x, pos_y;

  assign mag_x = sample.stick_x[STICK_W-1] ? AXIS_MAG_W'(-sample.stick_x)
                                           : AXIS_MAG_W'(sample.stick_x);
  assign mag_y = sample.stick_y_raw[STICK_W-1] ? AXIS_MAG_W'(-sample.stick_y_raw)
                                               : AXIS_MAG_W'(sample.stick_y_raw);
  assign pos_x = !sample.stick_x[STICK_W-1] && (sample.stick_x != '0);
  // The vertical axis is negated, so a negative raw value drives forward.
  assign pos_y = sample.stick_y_raw[STICK_W-1];

  logic                  a_valid;
  logic                  a_conn;
  logic                  a_pos_x, a_pos_y;
  logic                  a_live_x, a_live_y;
  logic [AXIS_MAG_W-1:0] a_diff_x, a_diff_y;

  always_ff @(posedge clk) begin
    if (rst) begin
      a_valid <= 1'b0;
    end else if (adv) begin
      a_valid <= sample.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      a_conn   <= sample.pad_connected;
      a_pos_x  <= pos_x;
      a_pos_y  <= pos_y;
      a_live_x <= mag_x >= AXIS_MAG_W'(deadzone_x);
      a_live_y <= mag_y >= AXIS_MAG_W'(deadzone_y);
      a_diff_x <= mag_x - AXIS_MAG_W'(deadzone_x);
      a_diff_y <= mag_y - AXIS_MAG_W'(deadzone_y);
    end
  end

  // --------------------------------------------------------------------------
  // Stage B: rescale numerator
  // --------------------------------------------------------------------------
  logic [AXIS_MAG_W+SPEED_W-1:0] prod_x, prod_y;

  assign prod_x = a_diff_x * max_speed;
  assign prod_y = a_diff_y * max_speed;

  logic                    b_valid;
  logic [AXIS_NUM_W-1:0]   b_num_x, b_num_y;
  jddm_pkg::axis_tag_t     b_tag_x, b_tag_y;
  logic [AXIS_DEN_W-1:0]   den_x, den_y;

  assign den_x = AXIS_DEN_W'(jddm_pkg::AXIS_FULL) - AXIS_DEN_W'(deadzone_x);
  assign den_y = AXIS_DEN_W'(jddm_pkg::AXIS_FULL) - AXIS_DEN_W'(deadzone_y);

  always_ff @(posedge clk) begin
    if (rst) begin
      b_valid <= 1'b0;
    end else if (adv) begin
      b_valid <= a_valid;
    end
  end

  // For a live axis the product never exceeds 1024 * 255, which fits the numerator width.
  always_ff @(posedge clk) begin
    if (adv) begin
      b_num_x <= prod_x[AXIS_NUM_W-1:0];
      b_num_y <= prod_y[AXIS_NUM_W-1:0];
      b_tag_x <= '{conn: a_conn, live: a_live_x, pos: a_pos_x};
      b_tag_y <= '{conn: a_conn, live: a_live_y, pos: a_pos_y};
    end
  end

  // --------------------------------------------------------------------------
  // Axis rescale dividers
  // --------------------------------------------------------------------------
  logic                                  x_valid, y_valid;
  logic [QUO_W-1:0]                      x_quo, y_quo;
  logic                                  x_ovf, y_ovf;
  logic [$bits(jddm_pkg::axis_tag_t)-1:0] x_side, y_side;
  jddm_pkg::axis_tag_t                   x_tag, y_tag;

  jddm_div_pipe #(
    .QW (QUO_W),
    .DW (AXIS_DEN_W),
    .SW ($bits(jddm_pkg::axis_tag_t))
  ) u_div_x (
    .clk       (clk),
    .rst       (rst),
    .en        (adv),
    .in_valid  (b_valid),
    .num       (b_num_x),
    .den       (den_x),
    .side_in   (b_tag_x),
    .out_valid (x_valid),
    .quo       (x_quo),
    .ovf       (x_ovf),
    .side_out  (x_side)
  );

  jddm_div_pipe #(
    .QW (QUO_W),
    .DW (AXIS_DEN_W),
    .SW ($bits(jddm_pkg::axis_tag_t))
  ) u_div_y (
    .clk       (clk),
    .rst       (rst),
    .en        (adv),
    .in_valid  (b_valid),
    .num       (b_num_y),
    .den       (den_y),
    .side_in   (b_tag_y),
    .out_valid (y_valid),
    .quo       (y_quo),
    .ovf       (y_ovf),
    .side_out  (y_side)
  );

  assign x_tag = jddm_pkg::axis_tag_t'(x_side);
  assign y_tag = jddm_pkg::axis_tag_t'(y_side);

  // --------------------------------------------------------------------------
  // Stage C: clamp to max_speed and restore sign
  // --------------------------------------------------------------------------
  logic [SPEED_W-1:0] turn_mag, fwd_mag;

  assign turn_mag = !x_tag.live ? '0 :
                    (x_ovf || (x_quo > max_speed)) ? max_speed : x_quo;
  assign fwd_mag  = !y_tag.live ? '0 :
                    (y_ovf || (y_quo > max_speed)) ? max_speed : y_quo;

  logic                      c_valid;
  logic                      c_conn;
  logic signed [SPEED_W:0]   c_fwd, c_turn;

  always_ff @(posedge clk) begin
    if (rst) begin
      c_valid <= 1'b0;
    end else if (adv) begin
      c_valid <= x_valid && y_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      c_conn <= x_tag.conn && y_tag.conn;
      c_fwd  <= y_tag.pos ? $signed({1'b0, fwd_mag}) : -$signed({1'b0, fwd_mag});
      c_turn <= x_tag.pos ? $signed({1'b0, turn_mag}) : -$signed({1'b0, turn_mag});
    end
  end

  // --------------------------------------------------------------------------
  // Stage D: mix into wheel speeds
  // --------------------------------------------------------------------------
  logic signed [SPEED_W+1:0] wl, wr;
  logic [SPEED_W-1:0]        fwd_abs, turn_abs;

  assign wl       = (SPEED_W+2)'(c_fwd) + (SPEED_W+2)'(c_turn);
  assign wr       = (SPEED_W+2)'(c_fwd) - (SPEED_W+2)'(c_turn);
  assign fwd_abs  = c_fwd[SPEED_W]  ? SPEED_W'(-c_fwd)  : SPEED_W'(c_fwd);
  assign turn_abs = c_turn[SPEED_W] ? SPEED_W'(-c_turn) : SPEED_W'(c_turn);

  logic                   d_valid;
  logic                   d_conn;
  logic                   d_neg_l, d_neg_r;
  logic [WHEEL_MAG_W-1:0] d_al, d_ar;
  logic [SPEED_W-1:0]     d_target;

  always_ff @(posedge clk) begin
    if (rst) begin
      d_valid <= 1'b0;
    end else if (adv) begin
      d_valid <= c_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      d_conn   <= c_conn;
      d_neg_l  <= wl[SPEED_W+1];
      d_neg_r  <= wr[SPEED_W+1];
      d_al     <= wl[SPEED_W+1] ? WHEEL_MAG_W'(-wl) : WHEEL_MAG_W'(wl);
      d_ar     <= wr[SPEED_W+1] ? WHEEL_MAG_W'(-wr) : WHEEL_MAG_W'(wr);
      d_target <= (fwd_abs > turn_abs) ? fwd_abs : turn_abs;
    end
  end

  // --------------------------------------------------------------------------
  // Stage E: normalization operands
  // --------------------------------------------------------------------------
  logic [WHEEL_MAG_W-1:0] largest;
  logic                   need;
  logic [WHEEL_NUM_W-1:0] prod_l, prod_r;

  assign largest = (d_al > d_ar) ? d_al : d_ar;
  assign need    = largest > WHEEL_MAG_W'(d_target);
  assign prod_l  = d_al * d_target;
  assign prod_r  = d_ar * d_target;

  logic                   e_valid;
  logic [WHEEL_NUM_W-1:0] e_num_l, e_num_r;
  logic [WHEEL_MAG_W-1:0] e_den;
  jddm_pkg::wheel_tag_t   e_tag_l, e_tag_r;

  always_ff @(posedge clk) begin
    if (rst) begin
      e_valid <= 1'b0;
    end else if (adv) begin
      e_valid <= d_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      e_num_l <= prod_l;
      e_num_r <= prod_r;
      e_den   <= largest;
      e_tag_l <= '{conn: d_conn, need: need, neg: d_neg_l, mag: d_al};
      e_tag_r <= '{conn: d_conn, need: need, neg: d_neg_r, mag: d_ar};
    end
  end

  // --------------------------------------------------------------------------
  // Wheel normalization dividers
  // --------------------------------------------------------------------------
  logic                                   l_valid, r_valid;
  logic [QUO_W-1:0]                       l_quo, r_quo;
  logic                                   l_ovf, r_ovf;
  logic [$bits(jddm_pkg::wheel_tag_t)-1:0] l_side, r_side;
  jddm_pkg::wheel_tag_t                   l_tag, r_tag;

  jddm_div_pipe #(
    .QW (QUO_W),
    .DW (WHEEL_MAG_W),
    .SW ($bits(jddm_pkg::wheel_tag_t))
  ) u_div_l (
    .clk       (clk),
    .rst       (rst),
    .en        (adv),
    .in_valid  (e_valid),
    .num       (e_num_l),
    .den       (e_den),
    .side_in   (e_tag_l),
    .out_valid (l_valid),
    .quo       (l_quo),
    .ovf       (l_ovf),
    .side_out  (l_side)
  );

  jddm_div_pipe #(
    .QW (QUO_W),
    .DW (WHEEL_MAG_W),
    .SW ($bits(jddm_pkg::wheel_tag_t))
  ) u_div_r (
    .clk       (clk),
    .rst       (rst),
    .en        (adv),
    .in_valid  (e_valid),
    .num       (e_num_r),
    .den       (e_den),
    .side_in   (e_tag_r),
    .out_valid (r_valid),
    .quo       (r_quo),
    .ovf       (r_ovf),
    .side_out  (r_side)
  );

  assign l_tag = jddm_pkg::wheel_tag_t'(l_side);
  assign r_tag = jddm_pkg::wheel_tag_t'(r_side);

  // --------------------------------------------------------------------------
  // Stage F: gain multiply
  // --------------------------------------------------------------------------
  // Without normalization the larger wheel is at most the larger axis, so the
  // magnitude already fits the quotient width.
  logic [QUO_W-1:0]       mag_l, mag_r;
  logic [GAIN_PROD_W-1:0] gprod_l, gprod_r;

  assign mag_l   = l_tag.need ? l_quo : l_tag.mag[QUO_W-1:0];
  assign mag_r   = r_tag.need ? r_quo : r_tag.mag[QUO_W-1:0];
  assign gprod_l = mag_l * gain_left;
  assign gprod_r = mag_r * gain_right;

  logic                   f_valid;
  logic                   f_conn;
  logic                   f_neg_l, f_neg_r;
  logic [GAIN_PROD_W-1:0] f_prod_l, f_prod_r;

  always_ff @(posedge clk) begin
    if (rst) begin
      f_valid <= 1'b0;
    end else if (adv) begin
      f_valid <= l_valid && r_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      f_conn   <= l_tag.conn && r_tag.conn;
      f_neg_l  <= l_tag.neg;
      f_neg_r  <= r_tag.neg;
      f_prod_l <= gprod_l;
      f_prod_r <= gprod_r;
    end
  end

  // --------------------------------------------------------------------------
  // Stage G: saturate and drive the output register
  // --------------------------------------------------------------------------
  function automatic logic [DUTY_BITS-1:0] wheel_duty(
    input logic [GAIN_PROD_W-1:0] prod,
    input logic [SPEED_W-1:0]     limit
  );
    logic [SCALED_W-1:0] scaled;
    logic [SPEED_W-1:0]  clipped;
    logic [SAT_W-1:0]    wide;
    scaled  = prod[GAIN_PROD_W-1:GAIN_SHIFT];
    clipped = (scaled > SCALED_W'(limit)) ? limit : scaled[SPEED_W-1:0];
    wide    = SAT_W'(clipped);
    if (wide > DUTY_MAX) begin
      wide = DUTY_MAX;
    end
    return wide[DUTY_BITS-1:0];
  endfunction

  logic [DUTY_BITS-1:0] duty_l, duty_r;

  // A missing controller stops both motors.
  assign duty_l = f_conn ? wheel_duty(f_prod_l, max_speed) : '0;
  assign duty_r = f_conn ? wheel_duty(f_prod_r, max_speed) : '0;

  logic                 out_left_fwd, out_left_rev;
  logic                 out_right_fwd, out_right_rev;
  logic [DUTY_BITS-1:0] out_left_duty, out_right_duty;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (adv) begin
      out_valid <= f_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      out_left_fwd   <= !f_neg_l && (duty_l != '0);
      out_left_rev   <= f_neg_l && (duty_l != '0);
      out_left_duty  <= duty_l;
      out_right_fwd  <= !f_neg_r && (duty_r != '0);
      out_right_rev  <= f_neg_r && (duty_r != '0);
      out_right_duty <= duty_r;
    end
  end

  assign result.valid      = out_valid;
  assign result.left_fwd   = out_left_fwd;
  assign result.left_rev   = out_left_rev;
  assign result.left_duty  = out_left_duty;
  assign result.right_fwd  = out_right_fwd;
  assign result.right_rev  = out_right_rev;
  assign result.right_duty = out_right_duty;

`ifndef SYNTHESIS
  // Normalization only divides by a wheel larger than the target, so the
  // quotient must always fit.
  assert property (@(posedge clk) disable iff (rst)
    (l_valid && l_tag.need) |-> !l_ovf)
    else $error("left wheel normalization quotient overflowed");

  assert property (@(posedge clk) disable iff (rst)
    (r_valid && r_tag.need) |-> !r_ovf)
    else $error("right wheel normalization quotient overflowed");

  // A direction bit is set exactly when the wheel has a nonzero duty.
  assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (((out_left_duty != '0) == (out_left_fwd || out_left_rev)) &&
                   ((out_right_duty != '0) == (out_right_fwd || out_right_rev))))
    else $error("direction bits disagree with duty");
`endif

endmodule

`default_nettype wire
